@@ hw/rtl/mtof_pkg.sv @@
// shared constants and types of the median time offset filter
`timescale 1ns / 1ps

package mtof_pkg;

  // table sizes
  localparam int MAX_SOURCES = 63;
  localparam int SRC_IDX_W   = 6;   // indexes the address table and holds its fill count
  localparam int OFS_IDX_W   = 6;   // indexes the sorted offset list (MAX_SOURCES + 1 entries)
  localparam int OFS_DEPTH   = MAX_SOURCES + 1;

  // field widths
  localparam int ADDR_W = 32;
  localparam int TIME_W = 40;
  localparam int OFS_W  = 41;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;

  // reset value of the sample threshold
  localparam logic [CNT_W-1:0] MIN_SAMPLES_RST = CNT_W'(5);

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

endpackage

@@ hw/rtl/mtof_if.sv @@
// valid/ready channel interfaces for time reports and filter results
`timescale 1ns / 1ps

interface mtof_in_if;
  logic                           valid;
  logic                           ready;
  logic [mtof_pkg::ADDR_W-1:0]    source_address;
  logic [mtof_pkg::TIME_W-1:0]    remote_time;
  logic [mtof_pkg::TIME_W-1:0]    local_time;

  modport source (output valid, source_address, remote_time, local_time, input ready);
  modport sink   (input valid, source_address, remote_time, local_time, output ready);
endinterface

interface mtof_out_if;
  logic                           valid;
  logic                           ready;
  logic [mtof_pkg::STAT_W-1:0]    status;
  logic [mtof_pkg::CNT_W-1:0]     sample_count;
  logic                           median_taken;
  logic signed [mtof_pkg::OFS_W-1:0] time_offset;

  modport source (output valid, status, sample_count, median_taken, time_offset, input ready);
  modport sink   (input valid, status, sample_count, median_taken, time_offset, output ready);
endinterface

@@ hw/rtl/median_time_offset_filter.sv @@
// median time offset filter: address table search, sorted insertion and median pick
// an accepted report is scanned against the address table, shifted into the offset memory one
// entry per cycle (up to 63 entries) and the median is picked when the list is long and odd
// enough; a duplicate of entry i ends the scan there, and a full table is scanned to its end;
// a new report is taken while the previous result still waits in the output register
// reset (rst_n, synchronous): empty table, seeded zero, offset zero, threshold 5; no clearing
`timescale 1ns / 1ps

module median_time_offset_filter (
  input  logic                          clk,
  input  logic                          rst_n,
  mtof_in_if.sink                       in_ch,
  mtof_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [mtof_pkg::CNT_W-1:0]    cfg_wdata
);
  import mtof_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_INS_RD,
    S_INS_CMP,
    S_MED_RD,
    S_MED_WAIT,
    S_DONE
  } state_t;

  // memories
  logic [ADDR_W-1:0]       known_mem [MAX_SOURCES];
  logic signed [OFS_W-1:0] offs_mem  [OFS_DEPTH];

  // control and working registers
  state_t                  state_r, state_nxt;
  logic [SRC_IDX_W-1:0]    src_count_r, src_count_nxt;
  logic [SRC_IDX_W-1:0]    sidx_r, sidx_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  logic [CNT_W-1:0]        ofs_count_r, ofs_count_nxt;
  logic [OFS_IDX_W-1:0]    pos_r, pos_nxt;
  logic signed [OFS_W-1:0] cur_ofs_r, cur_ofs_nxt;
  logic [CNT_W-1:0]        min_samples_r;
  logic                    seed_written_r, seed_written_nxt;
  logic                    rd_seed_r;
  logic [ADDR_W-1:0]       addr_r, addr_nxt;
  logic signed [OFS_W-1:0] new_ofs_r, new_ofs_nxt;
  status_t                 res_status_r, res_status_nxt;
  logic                    res_taken_r, res_taken_nxt;

  // output register
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [CNT_W-1:0]        out_count_r, out_count_nxt;
  logic                    out_taken_r, out_taken_nxt;
  logic signed [OFS_W-1:0] out_ofs_r, out_ofs_nxt;

  // memory strobes
  logic                    known_we;
  logic [SRC_IDX_W-1:0]    known_waddr;
  logic                    known_re;
  logic [SRC_IDX_W-1:0]    known_raddr;
  logic [ADDR_W-1:0]       known_q;
  logic                    offs_we;
  logic [OFS_IDX_W-1:0]    offs_waddr;
  logic signed [OFS_W-1:0] offs_wdata;
  logic                    offs_re;
  logic [OFS_IDX_W-1:0]    offs_raddr;
  logic signed [OFS_W-1:0] offs_q;
  logic signed [OFS_W-1:0] offs_rd;

  // seeded zero in entry 0 until that entry is first written
  assign offs_rd = rd_seed_r ? '0 : offs_q;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.sample_count = out_count_r;
  assign out_ch.median_taken = out_taken_r;
  assign out_ch.time_offset  = out_ofs_r;

  // address table memory
  always_ff @(posedge clk) begin
    if (known_we) begin
      known_mem[known_waddr] <= addr_r;
    end
    if (known_re) begin
      known_q <= known_mem[known_raddr];
    end
  end

  // sorted offset memory
  always_ff @(posedge clk) begin
    if (offs_we) begin
      offs_mem[offs_waddr] <= offs_wdata;
    end
    if (offs_re) begin
      offs_q <= offs_mem[offs_raddr];
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt        = state_r;
    src_count_nxt    = src_count_r;
    sidx_nxt         = sidx_r;
    rd_pend_nxt      = 1'b0;
    ofs_count_nxt    = ofs_count_r;
    pos_nxt          = pos_r;
    cur_ofs_nxt      = cur_ofs_r;
    seed_written_nxt = seed_written_r;
    addr_nxt         = addr_r;
    new_ofs_nxt      = new_ofs_r;
    res_status_nxt   = res_status_r;
    res_taken_nxt    = res_taken_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_status_nxt   = out_status_r;
    out_count_nxt    = out_count_r;
    out_taken_nxt    = out_taken_r;
    out_ofs_nxt      = out_ofs_r;
    known_we         = 1'b0;
    known_waddr      = src_count_r;
    known_re         = 1'b0;
    known_raddr      = sidx_r;
    offs_we          = 1'b0;
    offs_waddr       = pos_r;
    offs_wdata       = new_ofs_r;
    offs_re          = 1'b0;
    offs_raddr       = pos_r - OFS_IDX_W'(1);

    unique case (state_r)
      // take a report and form its offset
      S_IDLE: begin
        if (in_ch.valid) begin
          addr_nxt    = in_ch.source_address;
          new_ofs_nxt = $signed({1'b0, in_ch.remote_time}) - $signed({1'b0, in_ch.local_time});
          sidx_nxt    = '0;
          state_nxt   = S_SEARCH;
        end
      end

      // scan the address table, one read issued and one compare per cycle
      S_SEARCH: begin
        if (rd_pend_r && (known_q == addr_r)) begin
          res_status_nxt = ST_DUPLICATE;
          res_taken_nxt  = 1'b0;
          state_nxt      = S_DONE;
        end else if (sidx_r < src_count_r) begin
          known_re    = 1'b1;
          sidx_nxt    = sidx_r + SRC_IDX_W'(1);
          rd_pend_nxt = 1'b1;
        end else if (src_count_r == SRC_IDX_W'(MAX_SOURCES)) begin
          res_status_nxt = ST_FULL;
          res_taken_nxt  = 1'b0;
          state_nxt      = S_DONE;
        end else begin
          known_we       = 1'b1;
          src_count_nxt  = src_count_r + SRC_IDX_W'(1);
          pos_nxt        = ofs_count_r[OFS_IDX_W-1:0];
          res_status_nxt = ST_ACCEPTED;
          state_nxt      = S_INS_RD;
        end
      end

      // fetch the entry below the insertion point, or drop the offset in at the bottom
      S_INS_RD: begin
        if (pos_r == '0) begin
          offs_we          = 1'b1;
          seed_written_nxt = 1'b1;
          ofs_count_nxt    = ofs_count_r + CNT_W'(1);
          state_nxt        = S_MED_RD;
        end else begin
          offs_re   = 1'b1;
          state_nxt = S_INS_CMP;
        end
      end

      // shift a larger entry up, or place the new offset
      S_INS_CMP: begin
        if (offs_rd > new_ofs_r) begin
          offs_we    = 1'b1;
          offs_wdata = offs_rd;
          pos_nxt    = pos_r - OFS_IDX_W'(1);
          if (pos_r != OFS_IDX_W'(1)) begin
            offs_re    = 1'b1;
            offs_raddr = pos_r - OFS_IDX_W'(2);
          end else begin
            state_nxt = S_INS_RD;
          end
        end else begin
          offs_we       = 1'b1;
          ofs_count_nxt = ofs_count_r + CNT_W'(1);
          state_nxt     = S_MED_RD;
        end
      end

      // read the middle entry when the list is long enough and odd
      S_MED_RD: begin
        if ((ofs_count_r >= min_samples_r) && ofs_count_r[0]) begin
          offs_re    = 1'b1;
          offs_raddr = ofs_count_r[CNT_W-1:1];
          state_nxt  = S_MED_WAIT;
        end else begin
          res_taken_nxt = 1'b0;
          state_nxt     = S_DONE;
        end
      end

      // take the median as the new offset
      S_MED_WAIT: begin
        cur_ofs_nxt   = offs_rd;
        res_taken_nxt = 1'b1;
        state_nxt     = S_DONE;
      end

      // load the result once the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_count_nxt  = ofs_count_r;
          out_taken_nxt  = res_taken_r;
          out_ofs_nxt    = cur_ofs_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      src_count_r    <= '0;
      rd_pend_r      <= 1'b0;
      ofs_count_r    <= CNT_W'(1);
      cur_ofs_r      <= '0;
      seed_written_r <= 1'b0;
      rd_seed_r      <= 1'b0;
      out_valid_r    <= 1'b0;
      out_status_r   <= ST_ACCEPTED;
      out_count_r    <= '0;
      out_taken_r    <= 1'b0;
      out_ofs_r      <= '0;
      min_samples_r  <= MIN_SAMPLES_RST;
    end else begin
      state_r        <= state_nxt;
      src_count_r    <= src_count_nxt;
      rd_pend_r      <= rd_pend_nxt;
      ofs_count_r    <= ofs_count_nxt;
      cur_ofs_r      <= cur_ofs_nxt;
      seed_written_r <= seed_written_nxt;
      if (offs_re) begin
        rd_seed_r <= (offs_raddr == '0) && !seed_written_r;
      end
      out_valid_r    <= out_valid_nxt;
      out_status_r   <= out_status_nxt;
      out_count_r    <= out_count_nxt;
      out_taken_r    <= out_taken_nxt;
      out_ofs_r      <= out_ofs_nxt;
      if (cfg_we) begin
        min_samples_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sidx_r       <= sidx_nxt;
    pos_r        <= pos_nxt;
    addr_r       <= addr_nxt;
    new_ofs_r    <= new_ofs_nxt;
    res_status_r <= res_status_nxt;
    res_taken_r  <= res_taken_nxt;
  end

endmodule
